>>> hdl/rne_pkg.sv
`timescale 1ns / 1ps
// rne_pkg: shared types, character constants and radix helpers for the digit emitter
// no dependencies; used by rne_ctrl, rne_datapath and radix_n_digit_emitter
package rne_pkg;

	localparam logic [6:0] CHAR_ZERO     = 7'd48;
	localparam logic [6:0] CHAR_A        = 7'd65;
	localparam logic [5:0] DECIMAL_SPLIT = 6'd10;
	localparam logic [5:0] RADIX_RESET   = 6'd10;
	localparam logic [5:0] RADIX_MIN     = 6'd2;
	localparam logic [5:0] RADIX_MAX     = 6'd36;

	// commands from controller to datapath
	typedef struct packed {
		logic start;
		logic search_step;
		logic fetch;
		logic div_step;
		logic emit;
	} rne_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic search_done;
		logic div_done;
		logic k_zero;
		logic out_free;
	} rne_status_t;

	// saturate the programmed base into 2..36
	function automatic logic [5:0] eff_radix(input logic [5:0] r);
		logic [5:0] e;
		e = r;
		if (r < RADIX_MIN) begin
			e = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			e = RADIX_MAX;
		end
		return e;
	endfunction

	// index of the top quotient bit a digit can need, msb of (radix - 1)
	function automatic logic [2:0] quot_msb(input logic [5:0] r);
		logic [5:0] m;
		logic [2:0] idx;
		m = r - 6'd1;
		idx = 3'd0;
		for (int i = 0; i < 6; i++) begin
			if (m[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage

>>> hdl/rne_ram.sv
`timescale 1ns / 1ps
// rne_ram: generic single write port, single read port ram with registered read
// no dependencies
module rne_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/rne_ctrl.sv
`timescale 1ns / 1ps
// rne_ctrl: sequencer for power search, digit division and character hand-off
// depends on rne_pkg
module rne_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rne_pkg::rne_status_t status,
	output rne_pkg::rne_cmd_t    cmd,
	output logic                busy
);
	import rne_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_FETCH,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.start       = in_valid && !busy_q;
			S_SEARCH: cmd.search_step = 1'b1;
			S_FETCH:  cmd.fetch       = 1'b1;
			S_DIV:    cmd.div_step    = 1'b1;
			S_EMIT:   cmd.emit        = status.out_free;
			default:  cmd             = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_SEARCH;
						busy_q  <= 1'b1;
					end
				end
				S_SEARCH: begin
					if (status.search_done) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (status.div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (status.out_free) begin
						if (status.k_zero) begin
							state_q <= S_IDLE;
							busy_q  <= 1'b0;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

	// busy flag tracks the idle state exactly
	a_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) == !busy_q)
		else $error("busy flag out of step with idle state");

endmodule

>>> hdl/rne_datapath.sv
`timescale 1ns / 1ps
// rne_datapath: radix register, power stack ram, restoring digit divider, output register
// depends on rne_pkg and rne_ram
module rne_datapath #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [5:0]             radix,
	input  logic [VALUE_WIDTH-1:0] value,
	input  rne_pkg::rne_cmd_t      cmd,
	output rne_pkg::rne_status_t   status,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [6:0]             digit_char,
	output logic                   last_digit
);
	import rne_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int PW = VALUE_WIDTH + 6;
	localparam int AW = $clog2(VALUE_WIDTH);

	logic [5:0]    radix_q;
	logic [5:0]    eff;
	logic [2:0]    msb;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] pow_q;
	logic [AW-1:0] k_q;
	logic [2:0]    bit_q;
	logic [5:0]    dig_q;
	logic          out_valid_q;
	logic [6:0]    out_char_q;
	logic          out_last_q;

	logic [PW-1:0] prod;
	logic [PW-1:0] shifted;
	logic [VW-1:0] ram_rdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [6:0]    char_d;
	logic          k_zero;
	logic          out_free;

	assign cfg_ready = 1'b1;
	assign eff       = eff_radix(radix_q);
	assign msb       = quot_msb(eff);

	// next power candidate
	assign prod    = PW'(pow_q) * PW'(eff);
	assign shifted = PW'(ram_rdata) << bit_q;

	assign k_zero   = (k_q == '0);
	assign out_free = !out_valid_q || !out_stall;

	assign ram_re    = cmd.fetch || (cmd.emit && !k_zero);
	assign ram_raddr = cmd.fetch ? k_q : k_q - AW'(1);

	assign char_d = (dig_q >= DECIMAL_SPLIT) ? (7'(dig_q) - 7'(DECIMAL_SPLIT) + CHAR_A)
	                                         : (7'(dig_q) + CHAR_ZERO);

	assign status.search_done = (prod > PW'(rem_q));
	assign status.div_done    = (bit_q == 3'd0);
	assign status.k_zero      = k_zero;
	assign status.out_free    = out_free;

	rne_ram #(
		.WIDTH(VW),
		.DEPTH(VW)
	) u_pow_ram (
		.clk  (clk),
		.we   (cmd.search_step),
		.waddr(k_q),
		.wdata(pow_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				radix_q <= radix;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= value;
			pow_q <= VW'(1);
			k_q   <= '0;
		end
		if (cmd.search_step && !status.search_done) begin
			pow_q <= prod[VW-1:0];
			k_q   <= k_q + AW'(1);
		end
		if (cmd.fetch) begin
			bit_q <= msb;
			dig_q <= '0;
		end
		if (cmd.div_step) begin
			if (PW'(rem_q) >= shifted) begin
				rem_q <= rem_q - shifted[VW-1:0];
				dig_q <= dig_q | (6'd1 << bit_q);
			end
			bit_q <= bit_q - 3'd1;
		end
		if (cmd.emit) begin
			out_char_q <= char_d;
			out_last_q <= k_zero;
			if (!k_zero) begin
				k_q   <= k_q - AW'(1);
				bit_q <= msb;
				dig_q <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = out_char_q;
	assign last_digit = out_last_q;

	// a finished digit is always below the base
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (dig_q < eff))
		else $error("digit not below radix");

	// nothing is left over after the last character
	a_rem_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && k_zero) |-> (rem_q == '0))
		else $error("remainder left after final digit");

	// the power stack never runs past its last entry
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.search_step && !status.search_done) |-> (32'(k_q) < VW - 1))
		else $error("power stack overflow");

	// an emit never overwrites a word the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.emit)
		else $error("output word overwritten while stalled");

endmodule

>>> hdl/radix_n_digit_emitter.sv
`timescale 1ns / 1ps
// radix_n_digit_emitter: top level, integer to base-n ascii character stream
// depends on rne_pkg, rne_ctrl and rne_datapath (which holds rne_ram)
//
// usage
//   config: one register, radix, written through cfg_valid / cfg_ready (ready is
//   always high). bases outside 2..36 saturate to the nearest end. write it only
//   while the block is idle. reset value is 10.
//   input: value is taken when in_valid is high and in_stall is low. in_stall is
//   high from the accepted word until the last character of that number has been
//   loaded into the output register.
//   output: one word per character, most significant first, digit_char in ascii
//   ('0'-'9', then 'A'-'Z'), last_digit high on the final one. zero gives "0".
//   out_valid / out_stall: a stalled word holds; the block waits on the output
//   register, and the next number can be accepted while the last character waits.
// sequence, per number
//   the idle state takes the word, then a power search (one multiply and compare per
//   cycle) stacks the powers of the radix, a single ram fetch reads the highest, and
//   each digit is then found by a restoring divide and handed off
//   the powers found in the search are kept in a small ram and read back highest first
// reset: asynchronous, active low; clears the sequencer, output valid and radix
module radix_n_digit_emitter #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [5:0]             radix,
	// input word
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	// output word
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [6:0]             digit_char,
	output logic                   last_digit
);
	import rne_pkg::*;

	rne_cmd_t    cmd;
	rne_status_t status;
	logic        busy;

	// sequencer: idle, search, fetch, divide, emit
	rne_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy)
	);

	// radix register, power stack, digit divider and output register
	rne_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.radix     (radix),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.digit_char(digit_char),
		.last_digit(last_digit)
	);

	// one number at a time
	assign in_stall = busy;

endmodule
